/* rtl/assert_macros.svh */
// Assertion macros shared by the converter RTL.
// Each macro expects signals named clk and rst_n in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge out of reset.
`define ITP_ASSERT(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// An implication checked in the same cycle.
`define ITP_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// An implication whose consequent is checked in the cycle after the antecedent.
`define ITP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/itp_pkg.sv */
// Package for the infix-to-postfix converter: character codes, operator
// codes, character classes and decode functions. Depends on nothing.
`default_nettype none

package itp_pkg;

    localparam int CHAR_W = 8;

    // ASCII codes of the characters with a meaning of their own.
    localparam logic [CHAR_W-1:0] CH_OPEN  = 8'h28;
    localparam logic [CHAR_W-1:0] CH_CLOSE = 8'h29;
    localparam logic [CHAR_W-1:0] CH_MUL   = 8'h2A;
    localparam logic [CHAR_W-1:0] CH_ADD   = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_SUB   = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_DIV   = 8'h2F;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_NONE  = 8'h00;

    // Operator codes as stored on the stack.
    localparam int OP_W = 3;
    typedef enum logic [OP_W-1:0] {
        OP_OPEN = 3'd0,
        OP_ADD  = 3'd1,
        OP_SUB  = 3'd2,
        OP_MUL  = 3'd3,
        OP_DIV  = 3'd4
    } op_t;

    // What an incoming character does.
    typedef enum logic [2:0] {
        CL_OPERAND,
        CL_SPACE,
        CL_OPEN,
        CL_CLOSE,
        CL_ADDSUB,
        CL_MULDIV
    } cls_t;

    function automatic cls_t classify(input logic [CHAR_W-1:0] ch);
        cls_t c;
        unique case (ch)
            CH_OPEN:        c = CL_OPEN;
            CH_CLOSE:       c = CL_CLOSE;
            CH_ADD, CH_SUB: c = CL_ADDSUB;
            CH_MUL, CH_DIV: c = CL_MULDIV;
            CH_SPACE:       c = CL_SPACE;
            default:        c = CL_OPERAND;
        endcase
        return c;
    endfunction

    // Operator code that a character pushes; only meaningful for ( + - * /.
    function automatic op_t op_of(input logic [CHAR_W-1:0] ch);
        op_t o;
        unique case (ch)
            CH_ADD:  o = OP_ADD;
            CH_SUB:  o = OP_SUB;
            CH_MUL:  o = OP_MUL;
            CH_DIV:  o = OP_DIV;
            default: o = OP_OPEN;
        endcase
        return o;
    endfunction

    // Character emitted when an operator is popped.
    function automatic logic [CHAR_W-1:0] op_char(input logic [OP_W-1:0] op);
        logic [CHAR_W-1:0] c;
        unique case (op)
            OP_OPEN: c = CH_OPEN;
            OP_ADD:  c = CH_ADD;
            OP_SUB:  c = CH_SUB;
            OP_MUL:  c = CH_MUL;
            OP_DIV:  c = CH_DIV;
            default: c = CH_NONE;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

/* rtl/itp_in_if.sv */
// Input channel of the converter: one infix character per item.
// Depends on itp_pkg for the character width.
`default_nettype none

interface itp_in_if;
    logic                        valid;
    logic                        ready;
    logic [itp_pkg::CHAR_W-1:0]  in_char;
    logic                        last_in;

    modport source (output valid, output in_char, output last_in, input ready);
    modport sink   (input valid, input in_char, input last_in, output ready);
endinterface

`default_nettype wire

/* rtl/itp_out_if.sv */
// Output channel of the converter: one postfix character or end marker per item.
// Depends on itp_pkg for the character width.
`default_nettype none

interface itp_out_if;
    logic                        valid;
    logic                        ready;
    logic [itp_pkg::CHAR_W-1:0]  out_char;
    logic                        has_char;
    logic                        last_out;
    logic                        error;

    modport source (output valid, output out_char, output has_char, output last_out,
                    output error, input ready);
    modport sink   (input valid, input out_char, input has_char, input last_out,
                    input error, output ready);
endinterface

`default_nettype wire

/* rtl/itp_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies; read data holds while no read is issued.
`default_nettype none

module itp_ram #(
    parameter int WIDTH = 3,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

/* rtl/infix_to_postfix_converter_unit.sv */
// Top level of the shunting-yard infix-to-postfix converter.
// Depends on itp_pkg, itp_in_if, itp_out_if, itp_ram and assert_macros.svh.
//
//   channel  | direction | payload                                 | handshake
//   ---------+-----------+-----------------------------------------+------------
//   in_ch    | in        | in_char[7:0], last_in                   | valid/ready
//   out_ch   | out       | out_char[7:0], has_char, last_out, error| valid/ready
//
// An operand, a space, a '(' or anything on an empty stack is taken in S_IDLE and
// handled in S_ACT. Otherwise S_ACT issues the RAM read of the stack top and S_TEST
// tests it; every operator popped goes back through S_ACT (read) and S_TEST (test
// and emit). The final item then takes each flushed entry through S_FL and S_FLT,
// and S_DRAIN puts out the end result. A full output register stalls every emit
// that must pass it. Reset clears all control state; the stack needs none.
`default_nettype none
`include "assert_macros.svh"

module infix_to_postfix_converter_unit #(
    parameter int STACK_DEPTH = 32
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    itp_in_if.sink      in_ch,
    itp_out_if.source   out_ch
);

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(STACK_DEPTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ACT,
        S_TEST,
        S_FL,
        S_FLT,
        S_DRAIN
    } state_t;

    state_t                       state_reg,       state_next;
    logic [itp_pkg::CHAR_W-1:0]   char_reg,        char_next;
    itp_pkg::cls_t                cls_reg,         cls_next;
    itp_pkg::op_t                 op_reg,          op_next;
    logic                         last_reg,        last_next;
    logic [CW-1:0]                stack_count_reg, stack_count_next;
    logic                         error_seen_reg,  error_seen_next;
    logic                         hold_valid_reg,  hold_valid_next;
    logic [itp_pkg::CHAR_W-1:0]   hold_char_reg,   hold_char_next;
    logic                         out_valid_reg,   out_valid_next;
    logic [itp_pkg::CHAR_W-1:0]   out_char_reg,    out_char_next;
    logic                         out_has_reg,     out_has_next;
    logic                         out_last_reg,    out_last_next;
    logic                         out_error_reg,   out_error_next;

    logic                         ram_we;
    logic [AW-1:0]                ram_waddr;
    logic [itp_pkg::OP_W-1:0]     ram_wdata;
    logic                         ram_re;
    logic [AW-1:0]                ram_raddr;
    logic [itp_pkg::OP_W-1:0]     ram_rdata;

    logic [CW-1:0]                cnt_dec;
    logic                         stack_full;
    logic                         can_move;
    logic                         emit_ok;
    logic                         emit_req;
    logic [itp_pkg::CHAR_W-1:0]   emit_char;
    logic                         push_req;
    itp_pkg::op_t                 top_op;

    // Operator stack storage.
    itp_ram #(
        .WIDTH (itp_pkg::OP_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign cnt_dec    = stack_count_reg - CW'(1);
    assign stack_full = (stack_count_reg == DEPTH_C);
    assign can_move   = !out_valid_reg || out_ch.ready;
    assign top_op     = itp_pkg::op_t'(ram_rdata);
    assign ram_waddr  = stack_count_reg[AW-1:0];
    assign ram_wdata  = op_reg;
    assign ram_raddr  = cnt_dec[AW-1:0];

    // Results of the final item pass through a one-entry hold so the last one
    // can be tagged; other results go straight to the output register.
    assign emit_ok = last_reg ? (!hold_valid_reg || can_move) : can_move;

    // Sequencer: decode, stack test and pop, flush, end of expression.
    always_comb
    begin
        state_next       = state_reg;
        char_next        = char_reg;
        cls_next         = cls_reg;
        op_next          = op_reg;
        last_next        = last_reg;
        stack_count_next = stack_count_reg;
        error_seen_next  = error_seen_reg;
        hold_valid_next  = hold_valid_reg;
        hold_char_next   = hold_char_reg;
        out_valid_next   = out_valid_reg && !out_ch.ready;
        out_char_next    = out_char_reg;
        out_has_next     = out_has_reg;
        out_last_next    = out_last_reg;
        out_error_next   = out_error_reg;
        ram_re           = 1'b0;
        emit_req         = 1'b0;
        emit_char        = char_reg;
        push_req         = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_ch.valid)
                begin
                    char_next  = in_ch.in_char;
                    cls_next   = itp_pkg::classify(in_ch.in_char);
                    op_next    = itp_pkg::op_of(in_ch.in_char);
                    last_next  = in_ch.last_in;
                    state_next = S_ACT;
                end
            end

            S_ACT:
            begin
                unique case (cls_reg)
                    itp_pkg::CL_OPERAND:
                    begin
                        if (emit_ok)
                        begin
                            emit_req   = 1'b1;
                            state_next = last_reg ? S_FL : S_IDLE;
                        end
                    end
                    itp_pkg::CL_SPACE:
                    begin
                        state_next = last_reg ? S_FL : S_IDLE;
                    end
                    itp_pkg::CL_OPEN:
                    begin
                        push_req   = 1'b1;
                        state_next = last_reg ? S_FL : S_IDLE;
                    end
                    default:
                    begin
                        // Close, add/sub and mul/div all look at the top first.
                        if (stack_count_reg != '0)
                        begin
                            ram_re     = 1'b1;
                            state_next = S_TEST;
                        end
                        else
                        begin
                            if (cls_reg == itp_pkg::CL_CLOSE)
                            begin
                                error_seen_next = 1'b1;
                            end
                            else
                            begin
                                push_req = 1'b1;
                            end
                            state_next = last_reg ? S_FL : S_IDLE;
                        end
                    end
                endcase
            end

            S_TEST:
            begin
                priority if ((cls_reg == itp_pkg::CL_MULDIV) ?
                             (top_op == itp_pkg::OP_MUL || top_op == itp_pkg::OP_DIV) :
                             (top_op != itp_pkg::OP_OPEN))
                begin
                    // Pop and emit, then look at the new top.
                    if (emit_ok)
                    begin
                        emit_req         = 1'b1;
                        emit_char        = itp_pkg::op_char(top_op);
                        stack_count_next = cnt_dec;
                        state_next       = S_ACT;
                    end
                end
                else
                begin
                    if (cls_reg == itp_pkg::CL_CLOSE)
                    begin
                        // Drop the matching open parenthesis.
                        stack_count_next = cnt_dec;
                    end
                    else
                    begin
                        push_req = 1'b1;
                    end
                    state_next = last_reg ? S_FL : S_IDLE;
                end
            end

            S_FL:
            begin
                if (stack_count_reg != '0)
                begin
                    ram_re     = 1'b1;
                    state_next = S_FLT;
                end
                else
                begin
                    state_next = S_DRAIN;
                end
            end

            S_FLT:
            begin
                if (top_op == itp_pkg::OP_OPEN)
                begin
                    stack_count_next = cnt_dec;
                    error_seen_next  = 1'b1;
                    state_next       = S_FL;
                end
                else if (emit_ok)
                begin
                    emit_req         = 1'b1;
                    emit_char        = itp_pkg::op_char(top_op);
                    stack_count_next = cnt_dec;
                    state_next       = S_FL;
                end
            end

            S_DRAIN:
            begin
                // Final result: the held character, or an empty end marker.
                if (can_move)
                begin
                    out_valid_next   = 1'b1;
                    out_char_next    = hold_valid_reg ? hold_char_reg : itp_pkg::CH_NONE;
                    out_has_next     = hold_valid_reg;
                    out_last_next    = 1'b1;
                    out_error_next   = error_seen_reg;
                    hold_valid_next  = 1'b0;
                    stack_count_next = '0;
                    error_seen_next  = 1'b0;
                    state_next       = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Push onto the stack, or flag an overflow.
        ram_we = 1'b0;
        if (push_req)
        begin
            if (stack_full)
            begin
                error_seen_next = 1'b1;
            end
            else
            begin
                ram_we           = 1'b1;
                stack_count_next = stack_count_reg + CW'(1);
            end
        end

        // Route an emitted character to the output or through the hold.
        if (emit_req)
        begin
            if (!last_reg || hold_valid_reg)
            begin
                out_valid_next = 1'b1;
                out_char_next  = last_reg ? hold_char_reg : emit_char;
                out_has_next   = 1'b1;
                out_last_next  = 1'b0;
                out_error_next = 1'b0;
            end
            if (last_reg)
            begin
                hold_valid_next = 1'b1;
                hold_char_next  = emit_char;
            end
        end
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            char_reg        <= '0;
            cls_reg         <= itp_pkg::CL_SPACE;
            op_reg          <= itp_pkg::OP_OPEN;
            last_reg        <= 1'b0;
            stack_count_reg <= '0;
            error_seen_reg  <= 1'b0;
            hold_valid_reg  <= 1'b0;
            hold_char_reg   <= '0;
            out_valid_reg   <= 1'b0;
            out_char_reg    <= '0;
            out_has_reg     <= 1'b0;
            out_last_reg    <= 1'b0;
            out_error_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            char_reg        <= char_next;
            cls_reg         <= cls_next;
            op_reg          <= op_next;
            last_reg        <= last_next;
            stack_count_reg <= stack_count_next;
            error_seen_reg  <= error_seen_next;
            hold_valid_reg  <= hold_valid_next;
            hold_char_reg   <= hold_char_next;
            out_valid_reg   <= out_valid_next;
            out_char_reg    <= out_char_next;
            out_has_reg     <= out_has_next;
            out_last_reg    <= out_last_next;
            out_error_reg   <= out_error_next;
        end
    end

    // Port drive.
    assign in_ch.ready     = (state_reg == S_IDLE);
    assign out_ch.valid    = out_valid_reg;
    assign out_ch.out_char = out_char_reg;
    assign out_ch.has_char = out_has_reg;
    assign out_ch.last_out = out_last_reg;
    assign out_ch.error    = out_error_reg;

    // The stack count never passes the stack depth.
    `ITP_ASSERT(a_count_range, stack_count_reg <= DEPTH_C, "stack count above depth")
    // The stack is read only when it holds something.
    `ITP_ASSERT_IMP(a_read_nonempty, ram_re, stack_count_reg != '0, "read of empty stack")
    // The hold is only used while the final item of an expression is worked on.
    `ITP_ASSERT_IMP(a_hold_final, hold_valid_reg, last_reg && state_reg != S_IDLE,
        "hold used outside the final item")
    // Only the final result of an expression may carry the error flag.
    `ITP_ASSERT_IMP(a_error_last, out_valid_reg && out_error_reg, out_last_reg,
        "error flag on a result that is not final")
    // Closing an expression empties the stack and clears the error.
    `ITP_ASSERT_NEXT(a_end_clear, state_reg == S_DRAIN && can_move,
        stack_count_reg == '0 && !error_seen_reg && out_valid_reg && out_last_reg,
        "expression end did not clear state")

endmodule

`default_nettype wire

/* sim/tb.sv */
// Testbench for the shunting-yard infix-to-postfix converter unit.
// Depends on itp_pkg, itp_in_if, itp_out_if and the converter RTL; it
// predicts every postfix item in a shadow operator stack and checks each one.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STACK_DEPTH     = 32;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int ITEMS_PER_PHASE = 75;
    localparam int HOLD_CYCLES     = 300;
    localparam int SETTLE_CYCLES   = 100;
    localparam int NUM_PHASES      = 4;

    localparam int SEND_IDLE [NUM_PHASES]  = '{0, 52, 0, 26};
    localparam int RECV_STALL [NUM_PHASES] = '{0, 0, 52, 26};

    // Character printed for each stacked operator code.
    localparam logic [itp_pkg::CHAR_W-1:0] OP_GLYPH [5] =
        '{itp_pkg::CH_OPEN, itp_pkg::CH_ADD, itp_pkg::CH_SUB, itp_pkg::CH_MUL,
          itp_pkg::CH_DIV};
    localparam logic [itp_pkg::CHAR_W-1:0] OPERATORS [4] =
        '{itp_pkg::CH_ADD, itp_pkg::CH_SUB, itp_pkg::CH_MUL, itp_pkg::CH_DIV};
    localparam logic [itp_pkg::CHAR_W-1:0] SPECIALS [7] =
        '{itp_pkg::CH_OPEN, itp_pkg::CH_CLOSE, itp_pkg::CH_ADD, itp_pkg::CH_SUB,
          itp_pkg::CH_MUL, itp_pkg::CH_DIV, itp_pkg::CH_SPACE};

    typedef struct packed {
        logic [itp_pkg::CHAR_W-1:0] ch;
        logic                       last;
    } infix_t;

    typedef struct packed {
        logic [itp_pkg::CHAR_W-1:0] ch;
        logic                       has;
        logic                       last;
        logic                       err;
    } postfix_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    itp_in_if  in_ch();
    itp_out_if out_ch();

    infix_to_postfix_converter_unit #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // Infix characters waiting to be driven, and postfix items still due.
    infix_t   infix_q[$];
    postfix_t postfix_q[$];

    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    bit   hold_req = 1'b0;
    int   hold_left = 0;
    logic in_acc = 1'b0;
    int   fail_cnt = 0;
    int   cycle_cnt = 0;

    // Shadow copy of the operator stack.
    itp_pkg::op_t shadow_ops [STACK_DEPTH];
    int           shadow_depth = 0;
    bit           shadow_err = 1'b0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Push an operator; a full stack drops it and flags the expression.
    task automatic push_op(input itp_pkg::op_t op);
        if (shadow_depth >= STACK_DEPTH)
            shadow_err = 1'b1;
        else
        begin
            shadow_ops[shadow_depth] = op;
            shadow_depth++;
        end
    endtask

    // Pop the top operator and expect it as a postfix character.
    task automatic pop_op();
        postfix_q.push_back(postfix_t'{OP_GLYPH[shadow_ops[shadow_depth-1]], 1'b1, 1'b0, 1'b0});
        shadow_depth--;
    endtask

    // Work out the postfix items that one accepted infix character causes.
    task automatic convert_char(input logic [itp_pkg::CHAR_W-1:0] ch, input logic last);
        int       first;
        postfix_t tail;
        first = postfix_q.size();
        case (ch)
            itp_pkg::CH_OPEN: push_op(itp_pkg::OP_OPEN);
            itp_pkg::CH_CLOSE:
            begin
                while (shadow_depth > 0 && shadow_ops[shadow_depth-1] != itp_pkg::OP_OPEN)
                    pop_op();
                // A close with no open left is an error.
                if (shadow_depth > 0)
                    shadow_depth--;
                else
                    shadow_err = 1'b1;
            end
            itp_pkg::CH_ADD, itp_pkg::CH_SUB:
            begin
                while (shadow_depth > 0 && shadow_ops[shadow_depth-1] != itp_pkg::OP_OPEN)
                    pop_op();
                push_op(ch == itp_pkg::CH_ADD ? itp_pkg::OP_ADD : itp_pkg::OP_SUB);
            end
            itp_pkg::CH_MUL, itp_pkg::CH_DIV:
            begin
                while (shadow_depth > 0 &&
                       shadow_ops[shadow_depth-1] inside {itp_pkg::OP_MUL, itp_pkg::OP_DIV})
                    pop_op();
                push_op(ch == itp_pkg::CH_MUL ? itp_pkg::OP_MUL : itp_pkg::OP_DIV);
            end
            itp_pkg::CH_SPACE: ;
            default: postfix_q.push_back(postfix_t'{ch, 1'b1, 1'b0, 1'b0});
        endcase

        // At the end of the expression, flush; a leftover open is an error.
        if (last)
        begin
            while (shadow_depth > 0)
            begin
                if (shadow_ops[shadow_depth-1] == itp_pkg::OP_OPEN)
                begin
                    shadow_depth--;
                    shadow_err = 1'b1;
                end
                else
                    pop_op();
            end
            if (postfix_q.size() == first)
                postfix_q.push_back(postfix_t'{itp_pkg::CH_NONE, 1'b0, 1'b0, 1'b0});
            tail = postfix_q.pop_back();
            tail.last = 1'b1;
            tail.err = shadow_err;
            postfix_q.push_back(tail);
            shadow_depth = 0;
            shadow_err = 1'b0;
        end
    endtask

    // Input driver: a new item or an idle cycle once the last one was taken.
    always @(negedge clk)
    begin
        infix_t nxt;
        if (!rst_n)
            in_ch.valid <= 1'b0;
        else if (!in_ch.valid || in_acc)
        begin
            if (infix_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                nxt = infix_q.pop_front();
                in_ch.valid <= 1'b1;
                in_ch.in_char <= nxt.ch;
                in_ch.last_in <= nxt.last;
            end
            else
            begin
                in_ch.valid <= 1'b0;
                in_ch.in_char <= itp_pkg::CHAR_W'($urandom_range(255));
                in_ch.last_in <= 1'($urandom_range(1));
            end
        end
    end

    // Output ready: random stalls, or a long hold-off when one is requested.
    always @(negedge clk)
    begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else if (hold_left > 0)
        begin
            out_ch.ready <= 1'b0;
            hold_left--;
        end
        else if (hold_req)
        begin
            hold_req = 1'b0;
            hold_left = HOLD_CYCLES;
            out_ch.ready <= 1'b0;
        end
        else
            out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Monitor: predict on each accepted input item, check each output item.
    always @(posedge clk)
    begin
        postfix_t got;
        postfix_t want;
        in_acc <= rst_n && in_ch.valid && in_ch.ready;
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("FAIL infix_to_postfix_converter_unit");
            $finish;
        end
        else if (rst_n)
        begin
            if (in_ch.valid && in_ch.ready)
                convert_char(in_ch.in_char, in_ch.last_in);
            if (out_ch.valid && out_ch.ready)
            begin
                got = postfix_t'{out_ch.out_char, out_ch.has_char, out_ch.last_out,
                                 out_ch.error};
                if (postfix_q.size() == 0)
                begin
                    $error("unexpected item: out_char %h has_char %b last_out %b error %b",
                           got.ch, got.has, got.last, got.err);
                    fail_cnt++;
                end
                else
                begin
                    want = postfix_q.pop_front();
                    if (got.ch !== want.ch)
                    begin
                        $error("out_char: expected %h, actual %h", want.ch, got.ch);
                        fail_cnt++;
                    end
                    if (got.has !== want.has)
                    begin
                        $error("has_char: expected %b, actual %b", want.has, got.has);
                        fail_cnt++;
                    end
                    if (got.last !== want.last)
                    begin
                        $error("last_out: expected %b, actual %b", want.last, got.last);
                        fail_cnt++;
                    end
                    if (got.err !== want.err)
                    begin
                        $error("error: expected %b, actual %b", want.err, got.err);
                        fail_cnt++;
                    end
                end
            end
        end
    end

    task automatic add_char(input logic [itp_pkg::CHAR_W-1:0] ch, input logic last);
        infix_q.push_back(infix_t'{ch, last});
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            add_char(s[i], i == s.len() - 1);
    endtask

    task automatic add_expr(input logic [itp_pkg::CHAR_W-1:0] text[$]);
        for (int i = 0; i < text.size(); i++)
            add_char(text[i], i == text.size() - 1);
    endtask

    // Operand: a lowercase letter half the time, else any plain byte.
    function automatic logic [itp_pkg::CHAR_W-1:0] rand_operand();
        logic [itp_pkg::CHAR_W-1:0] ch;
        if ($urandom_range(1) == 0)
            return itp_pkg::CHAR_W'($urandom_range(8'h7A, 8'h61));
        do
            ch = itp_pkg::CHAR_W'($urandom_range(255));
        while (ch inside {itp_pkg::CH_OPEN, itp_pkg::CH_CLOSE, itp_pkg::CH_ADD,
                          itp_pkg::CH_SUB, itp_pkg::CH_MUL, itp_pkg::CH_DIV,
                          itp_pkg::CH_SPACE});
        return ch;
    endfunction

    // A well-formed expression with random operands, operators and nesting.
    task automatic gen_formula();
        logic [itp_pkg::CHAR_W-1:0] text[$];
        int opens;
        bit want_operand;
        int len;
        opens = 0;
        want_operand = 1'b1;
        len = $urandom_range(1, 14);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(9) == 0)
                text.push_back(itp_pkg::CH_SPACE);
            if (want_operand)
            begin
                if ($urandom_range(3) == 0 && opens < 8)
                begin
                    text.push_back(itp_pkg::CH_OPEN);
                    opens++;
                end
                else
                begin
                    text.push_back(rand_operand());
                    want_operand = 1'b0;
                end
            end
            else if (opens > 0 && $urandom_range(2) == 0)
            begin
                text.push_back(itp_pkg::CH_CLOSE);
                opens--;
            end
            else
            begin
                text.push_back(OPERATORS[$urandom_range(3)]);
                want_operand = 1'b1;
            end
        end
        if (want_operand)
            text.push_back(rand_operand());
        while (opens > 0)
        begin
            text.push_back(itp_pkg::CH_CLOSE);
            opens--;
        end
        add_expr(text);
    endtask

    // A short run of random characters, often with stray parentheses.
    task automatic gen_noise();
        logic [itp_pkg::CHAR_W-1:0] text[$];
        int len;
        len = $urandom_range(1, 8);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(9) < 6)
                text.push_back(SPECIALS[$urandom_range(6)]);
            else
                text.push_back(itp_pkg::CHAR_W'($urandom_range(255)));
        end
        add_expr(text);
    endtask

    // Deep nesting: each level stacks an open and an operator, so that
    // enough levels overflow the stack.
    task automatic gen_deep(input int levels);
        logic [itp_pkg::CHAR_W-1:0] text[$];
        int closes;
        closes = $urandom_range(levels);
        for (int i = 0; i < levels; i++)
        begin
            text.push_back(itp_pkg::CH_OPEN);
            text.push_back(rand_operand());
            text.push_back(OPERATORS[$urandom_range(3)]);
        end
        text.push_back(rand_operand());
        for (int i = 0; i < closes; i++)
            text.push_back(itp_pkg::CH_CLOSE);
        add_expr(text);
    endtask

    // Stimulus: directed cases, then random phases with different idling.
    initial
    begin
        int target;
        int pick;
        in_ch.valid = 1'b0;
        in_ch.in_char = itp_pkg::CH_NONE;
        in_ch.last_in = 1'b0;
        out_ch.ready = 1'b0;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            send_idle_pct = SEND_IDLE[ph];
            recv_stall_pct = RECV_STALL[ph];
            if (ph == 0)
            begin
                // Extreme bytes, spaces, every operator and both pop rules.
                add_char(8'h00, 1'b0);
                add_char(itp_pkg::CH_ADD, 1'b0);
                add_char(8'hFF, 1'b0);
                add_text(" *x/y-z");
                // Unmatched close, then an open left at the flush.
                add_text(")");
                add_text("(a");
                add_text("(a+b)*c");
                // Nothing emitted: only an empty end marker comes out.
                add_text(" ");
                // Hold the output off while the input keeps offering items.
                hold_req = 1'b1;
                gen_deep(18);
            end
            else if (ph == 2)
                gen_deep($urandom_range(14, 18));
            target = infix_q.size() + ITEMS_PER_PHASE;
            while (infix_q.size() < target)
            begin
                pick = $urandom_range(99);
                if (pick < 80)
                    gen_formula();
                else
                    gen_noise();
            end

            // Let every item go in, then pause until all results are back.
            while (infix_q.size() != 0 || in_ch.valid)
                @(posedge clk);
            while (postfix_q.size() != 0)
                @(posedge clk);
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_cnt == 0)
            $display("PASS infix_to_postfix_converter_unit");
        else
            $display("FAIL infix_to_postfix_converter_unit");
        $finish;
    end
endmodule
